// ----- rtl/cpu16_eu_pkg.sv -----
// Shared types, opcode and function codes, and reset constants of the
// cpu16 execute unit. No dependencies; imported by every other file.
package cpu16_eu_pkg;

  // Instruction classes
  localparam logic [2:0] OP_REG    = 3'd0;
  localparam logic [2:0] OP_IMM    = 3'd1;
  localparam logic [2:0] OP_BRANCH = 3'd2;
  localparam logic [2:0] OP_STORE  = 3'd3;
  localparam logic [2:0] OP_LOAD   = 3'd4;
  localparam logic [2:0] OP_JUMP   = 3'd5;
  localparam logic [2:0] OP_UPPER  = 3'd6;
  localparam logic [2:0] OP_SYSTEM = 3'd7;

  // Register class
  localparam logic [3:0] FR_ADD  = 4'h0;
  localparam logic [3:0] FR_SUB  = 4'h1;
  localparam logic [3:0] FR_SHL  = 4'h4;
  localparam logic [3:0] FR_SHR  = 4'h5;
  localparam logic [3:0] FR_SRA  = 4'h6;
  localparam logic [3:0] FR_OR   = 4'h7;
  localparam logic [3:0] FR_AND  = 4'h8;
  localparam logic [3:0] FR_XOR  = 4'h9;
  localparam logic [3:0] FR_JR   = 4'hB;
  localparam logic [3:0] FR_JALR = 4'hC;

  // Immediate class
  localparam logic [3:0] FI_ADD = 4'h0;
  localparam logic [3:0] FI_OR  = 4'h4;
  localparam logic [3:0] FI_AND = 4'h5;
  localparam logic [3:0] FI_XOR = 4'h6;
  localparam logic [3:0] FI_LI  = 4'h7;

  // Branch class
  localparam logic [3:0] FB_EQ  = 4'h0;
  localparam logic [3:0] FB_NE  = 4'h1;
  localparam logic [3:0] FB_EQZ = 4'h2;
  localparam logic [3:0] FB_NEZ = 4'h3;
  localparam logic [3:0] FB_LT  = 4'h4;
  localparam logic [3:0] FB_GE  = 4'h5;
  localparam logic [3:0] FB_LTU = 4'h6;
  localparam logic [3:0] FB_GEU = 4'h7;

  // Store and load classes
  localparam logic [3:0] FS_B  = 4'h0;
  localparam logic [3:0] FS_W  = 4'h1;
  localparam logic [3:0] FL_B  = 4'h0;
  localparam logic [3:0] FL_W  = 4'h1;
  localparam logic [3:0] FL_BU = 4'h4;

  localparam logic [15:0] PC_RESET = 16'h0020;
  localparam logic [15:0] PC_STEP  = 16'd2;
  localparam logic [2:0]  SP_INDEX = 3'd2;
  localparam logic [15:0] SP_RESET = 16'hEFFE;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         funct;
    logic [2:0]         dest_index;
    logic [2:0]         src1_index;
    logic [2:0]         src2_index;
    logic signed [15:0] imm_value;
    logic [6:0]         imm_raw7;
    logic               link_flag;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        reg_write_valid;
    logic [2:0]  reg_write_index;
    logic [15:0] reg_write_value;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [2:0] idx_a;
    logic [2:0] idx_b;
  } rf_rd_t;

  typedef struct packed {
    logic        en;
    logic [2:0]  idx;
    logic [15:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic        word;
    logic [15:0] addr;
    logic [15:0] wdata;
  } dmem_req_t;

  function automatic logic [15:0] reg_reset_value(input logic [2:0] idx);
    return (idx == SP_INDEX) ? SP_RESET : 16'h0000;
  endfunction

endpackage

// ----- rtl/cpu16_execute_unit.sv -----
// Execute stage of a 16-bit RISC core: register file, data memory and pc.
// An instruction passes the execute and result registers; a load also passes
// the data memory read. Throughput: one instruction per cycle while the result
// is not stalled; a load holds the stage while the data memory read completes.
// Reset (rst, synchronous): pc to 0x0020, registers to their reset values at
// once through per-entry written bits; data memory is not cleared.
module cpu16_execute_unit import cpu16_eu_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    instr_valid,
  output logic    instr_stall,
  input  instr_t  instr,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic        accept;
  logic        accept_ok;
  logic        out_free;
  logic        e_valid;
  instr_t      e_item;
  logic        e_load;
  logic        e_adv_alu;
  logic        e_adv_load;
  logic        m_valid;
  logic [3:0]  m_fn;
  logic [2:0]  m_dest;
  logic        m_done;
  logic [15:0] pc;

  rf_rd_t      rf_rd;
  rf_wr_t      rf_wr;
  logic [15:0] va;
  logic [15:0] vb;
  dmem_req_t   dmem_req;
  logic [15:0] dmem_rdata;
  logic [15:0] ld_val;

  logic [15:0] pc_inc;
  logic [15:0] imm;
  logic [15:0] ea;
  logic [15:0] branch_pc;
  logic [3:0]  sh;
  logic        take;
  logic        ex_wv;
  logic [15:0] ex_wval;
  logic [15:0] ex_pc;

  // While a load is in flight nothing new is read from the register file.
  assign out_free   = !result_valid || !result_stall;
  assign e_load     = (e_item.op == OP_LOAD) && (e_item.funct inside {FL_B, FL_W, FL_BU});
  assign e_adv_alu  = e_valid && !e_load && out_free;
  assign e_adv_load = e_valid && e_load;
  assign m_done     = m_valid && out_free;
  assign accept_ok  = (!e_valid || e_adv_alu) && (!m_valid || m_done);
  assign instr_stall = !accept_ok;
  assign accept     = instr_valid && accept_ok;

  assign rf_rd.en    = accept;
  assign rf_rd.idx_a = (instr.op == OP_REG || instr.op == OP_IMM) ?
                       instr.dest_index : instr.src1_index;
  assign rf_rd.idx_b = instr.src2_index;

  cpu16_eu_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd      (rf_rd),
    .wr      (rf_wr),
    .rdata_a (va),
    .rdata_b (vb)
  );

  assign pc_inc    = pc + PC_STEP;
  assign imm       = 16'(e_item.imm_value);
  assign ea        = va + imm;
  assign branch_pc = pc_inc + imm;
  assign sh        = vb[3:0];

  always_comb begin
    ex_wv   = 1'b0;
    ex_wval = 16'h0000;
    ex_pc   = pc_inc;
    take    = 1'b0;
    case (e_item.op)
      OP_REG: begin
        ex_wv = 1'b1;
        case (e_item.funct)
          FR_ADD:  ex_wval = va + vb;
          FR_SUB:  ex_wval = va - vb;
          FR_SHL:  ex_wval = va << sh;
          FR_SHR:  ex_wval = va >> sh;
          FR_SRA:  ex_wval = 16'($signed(va) >>> sh);
          FR_OR:   ex_wval = va | vb;
          FR_AND:  ex_wval = va & vb;
          FR_XOR:  ex_wval = va ^ vb;
          FR_JR: begin
            ex_wv = 1'b0;
            ex_pc = va;
          end
          FR_JALR: begin
            ex_wval = pc_inc;
            ex_pc   = vb;
          end
          default: ex_wv = 1'b0;
        endcase
      end
      OP_IMM: begin
        ex_wv = 1'b1;
        case (e_item.funct)
          FI_ADD:  ex_wval = va + imm;
          FI_OR:   ex_wval = va | {9'h000, e_item.imm_raw7};
          FI_AND:  ex_wval = va & imm;
          FI_XOR:  ex_wval = va ^ imm;
          FI_LI:   ex_wval = imm;
          default: ex_wv = 1'b0;
        endcase
      end
      OP_BRANCH: begin
        case (e_item.funct)
          FB_EQ:   take = (va == vb);
          FB_NE:   take = (va != vb);
          FB_EQZ:  take = (va == 16'h0000);
          FB_NEZ:  take = (va != 16'h0000);
          FB_LT:   take = ($signed(va) < $signed(vb));
          FB_GE:   take = ($signed(va) >= $signed(vb));
          FB_LTU:  take = (va < vb);
          FB_GEU:  take = (va >= vb);
          default: take = 1'b0;
        endcase
        if (take) begin
          ex_pc = branch_pc;
        end
      end
      OP_JUMP: begin
        if (e_item.link_flag) begin
          ex_wv   = 1'b1;
          ex_wval = pc_inc;
        end
        ex_pc = branch_pc;
      end
      OP_STORE, OP_LOAD, OP_UPPER, OP_SYSTEM: begin
        ex_wv = 1'b0;
      end
      default: ex_wv = 1'b0;
    endcase
  end

  assign dmem_req.rd_en = e_adv_load;
  assign dmem_req.wr_en = e_adv_alu && (e_item.op == OP_STORE) &&
                          (e_item.funct == FS_B || e_item.funct == FS_W);
  assign dmem_req.word  = (e_item.funct == FS_W);
  assign dmem_req.addr  = ea;
  assign dmem_req.wdata = vb;

  cpu16_eu_dmem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dmem (
    .clk   (clk),
    .req   (dmem_req),
    .rdata (dmem_rdata)
  );

  always_comb begin
    case (m_fn)
      FL_B:    ld_val = dmem_rdata[7] ? (16'hFF00 | {8'h00, dmem_rdata[7:0]})
                                      : {8'h00, dmem_rdata[7:0]};
      FL_W:    ld_val = dmem_rdata;
      default: ld_val = {8'h00, dmem_rdata[7:0]};
    endcase
  end

  // At most one of the execute and load-return paths writes in a cycle.
  assign rf_wr.en   = (e_adv_alu && ex_wv) || m_done;
  assign rf_wr.idx  = m_done ? m_dest : e_item.dest_index;
  assign rf_wr.data = m_done ? ld_val : ex_wval;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (accept) begin
      e_valid <= 1'b1;
    end else if (e_adv_alu || e_adv_load) begin
      e_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_item <= instr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (e_adv_load) begin
      m_valid <= 1'b1;
    end else if (m_done) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv_load) begin
      m_fn   <= e_item.funct;
      m_dest <= e_item.dest_index;
    end
  end

  // The pc moves on when an instruction leaves execute; a load's result later
  // reports this same value.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_RESET;
    end else if (e_adv_alu || e_adv_load) begin
      pc <= ex_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (e_adv_alu || m_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv_alu) begin
      result.next_pc         <= ex_pc;
      result.reg_write_valid <= ex_wv;
      result.reg_write_index <= ex_wv ? e_item.dest_index : 3'd0;
      result.reg_write_value <= ex_wv ? ex_wval : 16'h0000;
    end else if (m_done) begin
      result.next_pc         <= pc;
      result.reg_write_valid <= 1'b1;
      result.reg_write_index <= m_dest;
      result.reg_write_value <= ld_val;
    end
  end

endmodule

// ----- rtl/cpu16_eu_regfile.sv -----
// Eight-entry register file with two registered read ports and one write port.
// Depends on cpu16_eu_pkg for the port structs and the reset values.
module cpu16_eu_regfile import cpu16_eu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rf_rd_t      rd,
  input  rf_wr_t      wr,
  output logic [15:0] rdata_a,
  output logic [15:0] rdata_b
);

  logic [15:0] regs [8];
  logic [7:0]  written;
  logic [15:0] cur_a;
  logic [15:0] cur_b;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      regs[wr.idx] <= wr.data;
    end
  end

  // An entry not yet written reads as its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= 8'h00;
    end else if (wr.en) begin
      written[wr.idx] <= 1'b1;
    end
  end

  // A write landing at the same edge as the read is forwarded.
  always_comb begin
    if (wr.en && wr.idx == rd.idx_a) begin
      cur_a = wr.data;
    end else if (written[rd.idx_a]) begin
      cur_a = regs[rd.idx_a];
    end else begin
      cur_a = reg_reset_value(rd.idx_a);
    end
    if (wr.en && wr.idx == rd.idx_b) begin
      cur_b = wr.data;
    end else if (written[rd.idx_b]) begin
      cur_b = regs[rd.idx_b];
    end else begin
      cur_b = reg_reset_value(rd.idx_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_a <= cur_a;
      rdata_b <= cur_b;
    end
  end

endmodule

// ----- rtl/cpu16_eu_dmem.sv -----
// Byte-addressed data memory held as an even and an odd byte bank, so that a
// little-endian word is read or written in a single access. Depends on cpu16_eu_pkg.
module cpu16_eu_dmem import cpu16_eu_pkg::*; #(
  parameter int ADDR_BITS = 16
) (
  input  logic        clk,
  input  dmem_req_t   req,
  output logic [15:0] rdata
);

  localparam int BANK_BITS  = ADDR_BITS - 1;
  localparam int BANK_DEPTH = 1 << BANK_BITS;

  logic [7:0] bank_even [BANK_DEPTH];
  logic [7:0] bank_odd  [BANK_DEPTH];

  logic                 lane;
  logic [BANK_BITS-1:0] row;
  logic [BANK_BITS-1:0] even_row;
  logic                 even_we;
  logic                 odd_we;
  logic [7:0]           even_wdata;
  logic [7:0]           odd_wdata;
  logic [7:0]           even_q;
  logic [7:0]           odd_q;
  logic                 lane_q;

  // For an odd address the high byte of a word lies in the next even row.
  assign lane       = req.addr[0];
  assign row        = req.addr[ADDR_BITS-1:1];
  assign even_row   = lane ? row + BANK_BITS'(1) : row;
  assign even_we    = req.wr_en && (req.word || !lane);
  assign odd_we     = req.wr_en && (req.word || lane);
  assign even_wdata = lane ? req.wdata[15:8] : req.wdata[7:0];
  assign odd_wdata  = lane ? req.wdata[7:0] : req.wdata[15:8];

  always_ff @(posedge clk) begin
    if (even_we) begin
      bank_even[even_row] <= even_wdata;
    end
    if (req.rd_en) begin
      even_q <= bank_even[even_row];
    end
  end

  always_ff @(posedge clk) begin
    if (odd_we) begin
      bank_odd[row] <= odd_wdata;
    end
    if (req.rd_en) begin
      odd_q  <= bank_odd[row];
      lane_q <= lane;
    end
  end

  assign rdata = lane_q ? {even_q, odd_q} : {odd_q, even_q};

endmodule
